@@ design/stip_pkg.sv @@
// Shared constants and character helpers for the string-to-integer parser.
// No dependencies; used by string_to_integer_parser_top.
package stip_pkg;

    // Default widths of the internal value and index registers
    localparam int VALUE_BITS_DEF = 64;
    localparam int INDEX_BITS_DEF = 16;

    // Fixed port widths
    localparam int OUT_VALUE_W = 64;
    localparam int OUT_INDEX_W = 16;
    localparam int BASE_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 7;

    // Radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

    // Characters with a special role
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

    // Digit value of letters starts at ten
    localparam logic [DIGIT_W-1:0] DIGIT_LETTER = 7'd10;
    // Marks a byte that is no digit in any radix
    localparam logic [DIGIT_W-1:0] DIGIT_NONE   = 7'd99;
    localparam logic [DIGIT_W-1:0] DIGIT_HEX_LIM = 7'd16;

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
                d = DIGIT_W'(c - CH_ZERO);
            else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                d = DIGIT_W'(c - CH_UPPER_A) + DIGIT_LETTER;
            else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                d = DIGIT_W'(c - CH_LOWER_A) + DIGIT_LETTER;
            else
                d = DIGIT_NONE;
            return d;
        end
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

@@ design/string_to_integer_parser_top.sv @@
// String-to-integer parser, top level: input word register, conversion state,
// result register. Depends on stip_pkg.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------
//   in       | in_valid / in_ready       | start_req, character
//   out      | out_valid / out_ready     | value, overflow, no_digits, stop_index
//   cfg      | cfg_wr_en (no wait)       | cfg_wr_data (number_base)
//
// One input word per cycle while the result register is not stalled. A word
// is held in the input register, then one multiply-add with saturation check
// (accumulator times radix plus digit) updates the conversion state and, on
// the first non-digit, loads the result register, which drives out_valid.
// Reset leaves base 10 in the register and in the conversion state.
// A stalled result stops the state update only while the result register is
// full and not taken; the input register then holds and in_ready drops.
module string_to_integer_parser_top #(
    parameter int VALUE_BITS = stip_pkg::VALUE_BITS_DEF,
    parameter int INDEX_BITS = stip_pkg::INDEX_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_req,
    input  logic [stip_pkg::CHAR_W-1:0]       character,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [stip_pkg::OUT_VALUE_W-1:0] value,
    output logic                              overflow,
    output logic                              no_digits,
    output logic [stip_pkg::OUT_INDEX_W-1:0]  stop_index,
    input  logic                              cfg_wr_en,
    input  logic [stip_pkg::BASE_W-1:0]       cfg_wr_data
);

    localparam int PROD_W    = VALUE_BITS + 7;
    localparam int IDX_EXT_W = 32;
    localparam logic [VALUE_BITS-1:0] POS_LIMIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] NEG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGNED,
        PH_ZERO,
        PH_HEXMARK,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // configuration
    logic [stip_pkg::BASE_W-1:0] number_base_reg;

    // input word register
    logic                        in_valid_reg;
    logic                        start_reg;
    logic [stip_pkg::CHAR_W-1:0] char_reg;

    // conversion state
    phase_t                      phase_reg, phase_next;
    logic                        neg_reg, neg_next;
    logic [VALUE_BITS-1:0]       acc_reg, acc_next;
    logic [stip_pkg::BASE_W-1:0] eb_reg, eb_next;
    logic [INDEX_BITS-1:0]       idx_reg, idx_next;
    logic                        seen_reg, seen_next;
    logic                        sat_reg, sat_next;
    logic [INDEX_BITS-1:0]       zend_reg, zend_next;

    // result register
    logic                                 out_valid_reg;
    logic signed [stip_pkg::OUT_VALUE_W-1:0] value_reg, value_next;
    logic                                 overflow_reg, overflow_next;
    logic                                 no_digits_reg, no_digits_next;
    logic [stip_pkg::OUT_INDEX_W-1:0]     stop_reg, stop_next;

    // working values of the current word
    phase_t                      ph_cur;
    logic                        neg_cur;
    logic [VALUE_BITS-1:0]       acc_cur;
    logic [stip_pkg::BASE_W-1:0] eb_cur;
    logic [INDEX_BITS-1:0]       idx_cur;
    logic                        seen_cur;
    logic                        sat_cur;
    logic [INDEX_BITS-1:0]       zend_cur;
    logic [INDEX_BITS-1:0]       idx_inc;

    logic [stip_pkg::DIGIT_W-1:0] dval;
    logic [stip_pkg::BASE_W-1:0]  eb_use;
    logic                         try_first;
    logic                         try_digit;
    logic                         do_emit;
    logic [INDEX_BITS-1:0]        emit_stop;
    logic [IDX_EXT_W-1:0]         emit_stop_ext;
    logic [VALUE_BITS-1:0]        limit;
    logic [PROD_W-1:0]            mul_add;
    logic signed [VALUE_BITS-1:0] signed_val;

    logic stage_fire;
    logic in_fire;

    assign stage_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || stage_fire;
    assign in_fire    = in_valid && in_ready;

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign overflow   = overflow_reg;
    assign no_digits  = no_digits_reg;
    assign stop_index = stop_reg;

    // a start word restarts the conversion before it is parsed
    always_comb
    begin
        ph_cur   = start_reg ? PH_WS : phase_reg;
        neg_cur  = start_reg ? 1'b0 : neg_reg;
        acc_cur  = start_reg ? '0 : acc_reg;
        eb_cur   = start_reg ? number_base_reg : eb_reg;
        idx_cur  = start_reg ? '0 : idx_reg;
        seen_cur = start_reg ? 1'b0 : seen_reg;
        sat_cur  = start_reg ? 1'b0 : sat_reg;
        zend_cur = start_reg ? '0 : zend_reg;
    end

    assign idx_inc = (&idx_cur) ? idx_cur : idx_cur + 1'b1;
    assign dval    = stip_pkg::digit_value(char_reg);

    always_comb
    begin
        phase_next = ph_cur;
        neg_next   = neg_cur;
        acc_next   = acc_cur;
        eb_next    = eb_cur;
        idx_next   = idx_inc;
        seen_next  = seen_cur;
        sat_next   = sat_cur;
        zend_next  = zend_cur;
        eb_use     = eb_cur;
        try_first  = 1'b0;
        try_digit  = 1'b0;
        do_emit    = 1'b0;
        emit_stop  = idx_cur;

        case (ph_cur)
            PH_WS:
            begin
                if (stip_pkg::is_space(char_reg))
                begin
                    phase_next = PH_WS;
                end
                else if (char_reg == stip_pkg::CH_MINUS
                         || char_reg == stip_pkg::CH_PLUS)
                begin
                    neg_next   = (char_reg == stip_pkg::CH_MINUS);
                    phase_next = PH_SIGNED;
                end
                else
                begin
                    try_first = 1'b1;
                end
            end
            PH_SIGNED:
            begin
                try_first = 1'b1;
            end
            PH_ZERO:
            begin
                if (char_reg == stip_pkg::CH_LOWER_X
                    || char_reg == stip_pkg::CH_UPPER_X)
                begin
                    eb_next    = stip_pkg::BASE_HEX;
                    phase_next = PH_HEXMARK;
                end
                else
                begin
                    eb_use    = (eb_cur == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_OCT : eb_cur;
                    try_digit = 1'b1;
                end
            end
            PH_HEXMARK:
            begin
                if (dval < stip_pkg::DIGIT_HEX_LIM)
                begin
                    try_digit = 1'b1;
                end
                else
                begin
                    do_emit   = 1'b1;
                    emit_stop = zend_cur;
                end
            end
            PH_DIGITS:
            begin
                try_digit = 1'b1;
            end
            default:
            begin
                phase_next = ph_cur;
            end
        endcase

        // leading '0' may open a radix prefix
        if (try_first)
        begin
            if ((eb_cur == stip_pkg::BASE_AUTO || eb_cur == stip_pkg::BASE_HEX)
                && char_reg == stip_pkg::CH_ZERO)
            begin
                seen_next  = 1'b1;
                zend_next  = idx_inc;
                phase_next = PH_ZERO;
            end
            else
            begin
                eb_use    = (eb_cur == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : eb_cur;
                try_digit = 1'b1;
            end
        end

        limit   = neg_cur ? NEG_LIMIT : POS_LIMIT;
        mul_add = PROD_W'(acc_cur) * PROD_W'(eb_use) + PROD_W'(dval);

        if (try_digit)
        begin
            eb_next = eb_use;
            if (eb_use >= stip_pkg::BASE_MIN && eb_use <= stip_pkg::BASE_MAX
                && dval < stip_pkg::DIGIT_W'(eb_use))
            begin
                seen_next  = 1'b1;
                phase_next = PH_DIGITS;
                // keep consuming digits once saturated, value stays at the limit
                if (!sat_cur)
                begin
                    if (mul_add > PROD_W'(limit))
                    begin
                        acc_next = limit;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mul_add[VALUE_BITS-1:0];
                    end
                end
            end
            else
            begin
                do_emit   = 1'b1;
                emit_stop = idx_cur;
            end
        end

        if (do_emit)
        begin
            phase_next = PH_DONE;
        end

        signed_val     = neg_cur ? -acc_cur : acc_cur;
        emit_stop_ext  = IDX_EXT_W'(emit_stop);
        value_next     = stip_pkg::OUT_VALUE_W'(signed_val);
        overflow_next  = sat_cur;
        no_digits_next = !seen_cur;
        stop_next      = seen_cur ? emit_stop_ext[stip_pkg::OUT_INDEX_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= stip_pkg::BASE_RESET;
            in_valid_reg    <= 1'b0;
            start_reg       <= 1'b0;
            char_reg        <= '0;
            phase_reg       <= PH_WS;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            eb_reg          <= stip_pkg::BASE_RESET;
            idx_reg         <= '0;
            seen_reg        <= 1'b0;
            sat_reg         <= 1'b0;
            zend_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                number_base_reg <= cfg_wr_data;
            end

            if (in_fire)
            begin
                start_reg <= start_req;
                char_reg  <= character;
            end
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (stage_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (stage_fire)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                eb_reg    <= eb_next;
                idx_reg   <= idx_next;
                seen_reg  <= seen_next;
                sat_reg   <= sat_next;
                zend_reg  <= zend_next;
            end

            // load a result word, or drop the one just taken
            if (stage_fire && do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload carries no reset
    always_ff @(posedge clk)
    begin
        if (stage_fire && do_emit)
        begin
            value_reg     <= value_next;
            overflow_reg  <= overflow_next;
            no_digits_reg <= no_digits_next;
            stop_reg      <= stop_next;
        end
    end

    logic signed [stip_pkg::OUT_VALUE_W-1:0] pos_sat_ext;
    logic signed [stip_pkg::OUT_VALUE_W-1:0] neg_sat_ext;

    assign pos_sat_ext = stip_pkg::OUT_VALUE_W'($signed(POS_LIMIT));
    assign neg_sat_ext = stip_pkg::OUT_VALUE_W'($signed(NEG_LIMIT));

    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_digits |-> value == '0 && stop_index == '0)
        else $error("no-digit result with nonzero value or stop index");

    a_overflow_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> value == pos_sat_ext || value == neg_sat_ext)
        else $error("overflow result not at a saturation limit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && do_emit |=> out_valid && phase_reg == PH_DONE)
        else $error("emitted word did not reach the result register");

endmodule

@@ sim/tb.sv @@
// Testbench for string_to_integer_parser_top: directed strings, then random strings
// under changing radix settings, with a scoreboard that tracks the conversion state.
// Depends on stip_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_WORDS = 1050;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [stip_pkg::BASE_W-1:0] BASE_BAD_LOW  = 6'd1;
    localparam logic [stip_pkg::BASE_W-1:0] BASE_BAD_HIGH = 6'd37;
    localparam logic [stip_pkg::BASE_W-1:0] BASE_ALL_ONES = 6'd63;

    // Tracks one conversion at a time and queues a result whenever a word ends the conversion.
    class parse_scoreboard;
        typedef enum logic [2:0] {
            SCAN_BLANKS, SCAN_SIGNED, SCAN_ZERO, SCAN_HEXMARK, SCAN_DIGITS, SCAN_DONE
        } scan_phase_t;

        typedef struct {
            logic signed [63:0] value;
            logic               overflow;
            logic               no_digits;
            logic [15:0]        stop_index;
        } conversion_t;

        localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
        localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
        localparam logic [6:0]  NOT_DIGIT = 7'd99;
        localparam logic [6:0]  HEX_RADIX = 7'd16;
        localparam logic [15:0] INDEX_TOP = 16'hFFFF;

        conversion_t                 conversions_q[$];
        int                          n_errors;
        logic [stip_pkg::BASE_W-1:0] number_base;
        logic [stip_pkg::BASE_W-1:0] eff_base;
        scan_phase_t                 phase;
        logic                        negative;
        logic                        digit_seen;
        logic                        saturated;
        logic [63:0]                 magnitude;
        logic [15:0]                 char_index;
        logic [15:0]                 zero_end_index;

        function new();
            n_errors       = 0;
            number_base    = stip_pkg::BASE_RESET;
            eff_base       = stip_pkg::BASE_RESET;
            phase          = SCAN_BLANKS;
            negative       = 1'b0;
            digit_seen     = 1'b0;
            saturated      = 1'b0;
            magnitude      = '0;
            char_index     = '0;
            zero_end_index = '0;
        endfunction

        static function logic [6:0] digit_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return 7'(c - "0");
            if (c >= "A" && c <= "Z") return 7'(c - "A") + 7'd10;
            if (c >= "a" && c <= "z") return 7'(c - "a") + 7'd10;
            return NOT_DIGIT;
        endfunction

        function logic is_blank(logic [7:0] c);
            return c == " " || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function logic [15:0] step_index(logic [15:0] i);
            return (i == INDEX_TOP) ? i : i + 16'd1;
        endfunction

        function int pending();
            return conversions_q.size();
        endfunction

        function void write_base(logic [stip_pkg::BASE_W-1:0] b);
            number_base = b;
        endfunction

        function void emit(logic [15:0] stop);
            conversion_t r;
            r.value      = negative ? (64'd0 - magnitude) : magnitude;
            r.overflow   = saturated;
            r.no_digits  = !digit_seen;
            r.stop_index = digit_seen ? stop : 16'd0;
            conversions_q.push_back(r);
            phase = SCAN_DONE;
        endfunction

        function void accumulate(logic [6:0] d);
            logic [63:0] limit;
            limit      = negative ? NEG_LIMIT : POS_LIMIT;
            digit_seen = 1'b1;
            if (!saturated)
            begin
                if (magnitude > (limit - 64'(d)) / 64'(eff_base))
                begin
                    magnitude = limit;
                    saturated = 1'b1;
                end
                else
                begin
                    magnitude = magnitude * 64'(eff_base) + 64'(d);
                end
            end
        endfunction

        function void take_digit(logic [7:0] c);
            logic [6:0] d;
            d = digit_of(c);
            if (eff_base >= stip_pkg::BASE_MIN && eff_base <= stip_pkg::BASE_MAX
                && d < 7'(eff_base))
            begin
                accumulate(d);
                phase = SCAN_DIGITS;
            end
            else
            begin
                emit(char_index);
            end
        endfunction

        function void take_first(logic [7:0] c);
            if ((eff_base == stip_pkg::BASE_AUTO || eff_base == stip_pkg::BASE_HEX)
                && c == "0")
            begin
                digit_seen     = 1'b1;
                zero_end_index = step_index(char_index);
                phase          = SCAN_ZERO;
            end
            else
            begin
                if (eff_base == stip_pkg::BASE_AUTO) eff_base = stip_pkg::BASE_DEC;
                take_digit(c);
            end
        endfunction

        function void take_after_zero(logic [7:0] c);
            if (c == "x" || c == "X")
            begin
                eff_base = stip_pkg::BASE_HEX;
                phase    = SCAN_HEXMARK;
            end
            else
            begin
                if (eff_base == stip_pkg::BASE_AUTO) eff_base = stip_pkg::BASE_OCT;
                take_digit(c);
            end
        endfunction

        function void note_word(logic s, logic [7:0] c);
            if (s)
            begin
                phase          = SCAN_BLANKS;
                negative       = 1'b0;
                magnitude      = '0;
                eff_base       = number_base;
                char_index     = '0;
                digit_seen     = 1'b0;
                saturated      = 1'b0;
                zero_end_index = '0;
            end
            case (phase)
                SCAN_BLANKS:
                    if (!is_blank(c))
                    begin
                        if (c == "-" || c == "+")
                        begin
                            negative = (c == "-");
                            phase    = SCAN_SIGNED;
                        end
                        else
                        begin
                            take_first(c);
                        end
                    end
                SCAN_SIGNED:  take_first(c);
                SCAN_ZERO:    take_after_zero(c);
                SCAN_HEXMARK:
                    if (digit_of(c) < HEX_RADIX) take_digit(c);
                    else emit(zero_end_index);
                SCAN_DIGITS:  take_digit(c);
                default: ;
            endcase
            char_index = step_index(char_index);
        endfunction

        function void check_result(logic signed [63:0] v, logic ovf, logic nd,
                                   logic [15:0] si);
            conversion_t e;
            if (conversions_q.size() == 0)
            begin
                $display("%0t: unexpected result value %0d overflow %0b no_digits %0b stop %0d",
                         $time, v, ovf, nd, si);
                n_errors++;
                return;
            end
            e = conversions_q.pop_front();
            if (v !== e.value)
            begin
                $display("%0t: value expected %0d actual %0d", $time, e.value, v);
                n_errors++;
            end
            if (ovf !== e.overflow)
            begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.overflow, ovf);
                n_errors++;
            end
            if (nd !== e.no_digits)
            begin
                $display("%0t: no_digits expected %0b actual %0b", $time, e.no_digits, nd);
                n_errors++;
            end
            if (si !== e.stop_index)
            begin
                $display("%0t: stop_index expected %0d actual %0d", $time, e.stop_index, si);
                n_errors++;
            end
        endfunction
    endclass

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    logic                                   start_req = 1'b0;
    logic [stip_pkg::CHAR_W-1:0]            character = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [stip_pkg::OUT_VALUE_W-1:0] value;
    logic                                   overflow;
    logic                                   no_digits;
    logic [stip_pkg::OUT_INDEX_W-1:0]       stop_index;
    logic                                   cfg_wr_en = 1'b0;
    logic [stip_pkg::BASE_W-1:0]            cfg_wr_data = '0;

    parse_scoreboard sb;
    int  send_idle_pct = 8;
    int  recv_idle_pct = 46;
    int  words_sent = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_armed = 1'b0;
    bit  hold_started = 1'b0;

    string_to_integer_parser_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_req  (start_req),
        .character  (character),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .overflow   (overflow),
        .no_digits  (no_digits),
        .stop_index (stop_index),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("string_to_integer_parser_top test failed");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_armed && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready) sb.note_word(start_req, character);
            if (out_valid && out_ready) sb.check_result(value, overflow, no_digits, stop_index);
        end
    end

    task automatic send_word(input logic s, input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= s;
        character <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_text(input string s, input bit with_start);
        for (int i = 0; i < s.len(); i++)
            send_word(with_start && i == 0, s[i]);
    endtask

    // Radix changes only while the parser is quiet
    task automatic set_base(input logic [stip_pkg::BASE_W-1:0] b);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_base(b);
    endtask

    function automatic logic [stip_pkg::BASE_W-1:0] pick_base();
        case ($urandom_range(0, 13))
            0:       return stip_pkg::BASE_AUTO;
            1:       return stip_pkg::BASE_MIN;
            2:       return stip_pkg::BASE_OCT;
            3:       return stip_pkg::BASE_DEC;
            4:       return stip_pkg::BASE_HEX;
            5:       return stip_pkg::BASE_MAX;
            6:       return BASE_BAD_LOW;
            7:       return BASE_BAD_HIGH;
            8:       return BASE_ALL_ONES;
            9:       return stip_pkg::BASE_AUTO;
            10:      return stip_pkg::BASE_HEX;
            11:      return 6'($urandom_range(0, 63));
            default: return 6'($urandom_range(2, 36));
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'("0" + d);
        return $urandom_range(0, 1) ? 8'("a" + d - 10) : 8'("A" + d - 10);
    endfunction

    task automatic send_random_string(input logic [stip_pkg::BASE_W-1:0] b);
        int          n;
        int          eb;
        int          mode;
        logic [7:0]  c;
        bit          first;
        // Noise: raw bytes with a start here and there
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
            begin
                send_word(i == 0 || $urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
                words_sent++;
            end
            return;
        end
        first = 1'b1;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            c = ($urandom_range(0, 5) == 5) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4));
            send_word(first, c);
            first = 1'b0;
            words_sent++;
        end
        case ($urandom_range(0, 2))
            1:
            begin
                send_word(first, "+");
                first = 1'b0;
                words_sent++;
            end
            2:
            begin
                send_word(first, "-");
                first = 1'b0;
                words_sent++;
            end
            default: ;
        endcase
        mode = 2;
        if (b == stip_pkg::BASE_AUTO) mode = $urandom_range(0, 2);
        else if (b == stip_pkg::BASE_HEX) mode = $urandom_range(0, 1) ? 0 : 2;
        if (mode == 0 && (b == stip_pkg::BASE_AUTO || b == stip_pkg::BASE_HEX))
        begin
            send_word(first, "0");
            send_word(1'b0, $urandom_range(0, 1) ? "x" : "X");
            first = 1'b0;
            words_sent += 2;
            eb = stip_pkg::BASE_HEX;
        end
        else if (mode == 1)
        begin
            send_word(first, "0");
            first = 1'b0;
            words_sent++;
            eb = stip_pkg::BASE_OCT;
        end
        else if (b == stip_pkg::BASE_AUTO) eb = stip_pkg::BASE_DEC;
        else if (b >= stip_pkg::BASE_MIN && b <= stip_pkg::BASE_MAX) eb = b;
        else eb = 0;
        if ($urandom_range(0, 11) == 0) n = 0;
        else if ($urandom_range(0, 3) == 0) n = $urandom_range(15, 66);
        else n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if (eb == 0) c = digit_char($urandom_range(0, 9));
            else if (b == stip_pkg::BASE_AUTO && eb == stip_pkg::BASE_DEC && i == 0)
                c = digit_char($urandom_range(1, 9));
            else c = digit_char($urandom_range(0, eb - 1));
            send_word(first, c);
            first = 1'b0;
            words_sent++;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            c = 8'h00;
        end
        else
        begin
            do c = 8'($urandom_range(0, 255));
            while (eb != 0 && parse_scoreboard::digit_of(c) < 7'(eb));
        end
        send_word(first, c);
        words_sent++;
        // Trailing bytes after the terminator are dropped by the parser
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            send_word(1'b0, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [stip_pkg::BASE_W-1:0] cur_base;
        int                          strings_done;
        bit                          hold_done;
        sb = new();
        strings_done = 0;
        hold_done    = 1'b0;
        cur_base     = stip_pkg::BASE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before any start the parser runs in base 10 regardless of the register
        set_base(stip_pkg::BASE_HEX);
        send_text("12;", 1'b0);

        set_base(stip_pkg::BASE_DEC);
        for (int i = 0; i < 6; i++)
            send_word(i == 0, (i == 0) ? 8'h20 : 8'(8'h09 + i - 1));
        send_text("-42!", 1'b0);
        send_text("+7", 1'b1);
        send_word(1'b0, 8'h00);
        send_text("9223372036854775807 ", 1'b1);
        send_text("9223372036854775808 ", 1'b1);
        send_text("-9223372036854775808 ", 1'b1);
        send_text("-922337203685477580912345,", 1'b1);
        send_text("-,", 1'b1);
        send_text("abc", 1'b1);
        send_text("5z999", 1'b1);
        send_text("12", 1'b1);
        send_text("34;", 1'b1);

        set_base(stip_pkg::BASE_AUTO);
        send_text("0x1fZ", 1'b1);
        send_text("0Xg", 1'b1);
        send_text("-017 ", 1'b1);
        send_text("08", 1'b1);
        send_text("0", 1'b1);
        send_word(1'b0, 8'h00);
        send_text("123;", 1'b1);
        send_text("0x8000000000000000 ", 1'b1);

        set_base(stip_pkg::BASE_HEX);
        send_text("0xFF ", 1'b1);
        send_text("ff.", 1'b1);
        send_text("0x!", 1'b1);

        set_base(stip_pkg::BASE_MIN);
        send_text("1011 ", 1'b1);
        send_text("-1012", 1'b1);

        set_base(stip_pkg::BASE_MAX);
        send_text("zZ9-", 1'b1);
        send_text("Zzzzzzzzzzzzzzz!", 1'b1);

        set_base(stip_pkg::BASE_OCT);
        send_text("7778", 1'b1);

        set_base(BASE_BAD_LOW);
        send_text("1 ", 1'b1);
        set_base(BASE_BAD_HIGH);
        send_text("  +9", 1'b1);
        set_base(BASE_ALL_ONES);
        send_text("z", 1'b1);

        words_sent = 0;
        for (int phase_no = 0; phase_no < 3; phase_no++)
        begin
            case (phase_no)
                0:
                begin
                    send_idle_pct = 8;
                    recv_idle_pct = 46;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_idle_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (words_sent < (phase_no + 1) * RANDOM_WORDS / 3)
            begin
                if (strings_done % 16 == 0)
                begin
                    cur_base = pick_base();
                    set_base(cur_base);
                end
                // Stall the result side long enough to back up the input
                if (phase_no == 0 && !hold_done && words_sent > 150)
                begin
                    hold_armed = 1'b1;
                    hold_done  = 1'b1;
                end
                send_random_string(cur_base);
                strings_done++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.n_errors == 0)
            $display("string_to_integer_parser_top test passed");
        else
            $display("string_to_integer_parser_top test failed");
        $finish;
    end

endmodule
